@@ rtl/control_surface_input_events_macros.svh @@
// Assertion macros used by the event block checker.
`ifndef CONTROL_SURFACE_INPUT_EVENTS_MACROS_SVH
`define CONTROL_SURFACE_INPUT_EVENTS_MACROS_SVH

// Check that a condition implies another one in the next cycle.
`define CSIE_ASSERT_NEXT(lbl, clk_s, rstn_s, ante, cons) \
  lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

// Check that a condition implies another one in the same cycle.
`define CSIE_ASSERT_SAME(lbl, clk_s, rstn_s, ante, cons) \
  lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |-> (cons)) \
    else $error("same-cycle check failed");

`endif

@@ rtl/csie_pkg.sv @@
// Shared types and constants of the control-surface event block.
package csie_pkg;

  localparam int BUTTON_BITS_DEF = 32;
  localparam int PAD_COUNT_DEF   = 16;

  localparam int IN_TDATA_W  = 56;
  localparam int OUT_TDATA_W = 24;
  localparam int EVT_KIND_W  = 2;
  localparam int PRESS_W     = 12;

  localparam logic [PRESS_W-1:0] THRESHOLD_RESET = 12'd200;

  // Register index of pad_threshold on the configuration port
  localparam logic REG_PAD_THRESHOLD = 1'b0;

  // Report kinds on the input channel
  localparam logic OP_BUTTON = 1'b0;
  localparam logic OP_PAD    = 1'b1;

  typedef enum logic [EVT_KIND_W-1:0] {
    EV_BUTTON  = 2'd0,
    EV_ENCODER = 2'd1,
    EV_PRESS   = 2'd2,
    EV_RELEASE = 2'd3
  } event_kind_t;

  typedef enum logic [1:0] {
    SRC_BTN = 2'd0,
    SRC_ENC = 2'd1,
    SRC_PAD = 2'd2
  } out_src_t;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic     load_btn;
    logic     load_pad;
    logic     scan_adv;
    logic     out_load;
    out_src_t out_src;
  } cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic cur_bit;
    logic diff_empty;
    logic enc_pend;
    logic pad_event;
    logic out_free;
  } status_t;

endpackage

@@ rtl/csie_ctrl.sv @@
// Controller state machine that sequences the event scan.
module csie_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_tvalid,
  input  logic             in_op,
  output logic             in_tready,
  input  csie_pkg::status_t sts,
  output csie_pkg::cmd_t    cmd
);
  import csie_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_BTN  = 4'b0010,
    S_ENC  = 4'b0100,
    S_PAD  = 4'b1000
  } state_t;

  state_t state_r, state_nxt;

  // Advance the state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Decode commands and next state
  always_comb begin
    state_nxt    = state_r;
    in_tready    = 1'b0;
    cmd.load_btn = 1'b0;
    cmd.load_pad = 1'b0;
    cmd.scan_adv = 1'b0;
    cmd.out_load = 1'b0;
    cmd.out_src  = SRC_BTN;
    case (state_r)
      S_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          if (in_op == OP_PAD) begin
            cmd.load_pad = 1'b1;
            state_nxt    = S_PAD;
          end else begin
            cmd.load_btn = 1'b1;
            state_nxt    = S_BTN;
          end
        end
      end
      S_BTN: begin
        // walk the change mask, one position per cycle, stall on a full output
        if (sts.diff_empty) begin
          state_nxt = sts.enc_pend ? S_ENC : S_IDLE;
        end else if (!sts.cur_bit) begin
          cmd.scan_adv = 1'b1;
        end else if (sts.out_free) begin
          cmd.scan_adv = 1'b1;
          cmd.out_load = 1'b1;
          cmd.out_src  = SRC_BTN;
        end
      end
      S_ENC: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          cmd.out_src  = SRC_ENC;
          state_nxt    = S_IDLE;
        end
      end
      S_PAD: begin
        if (!sts.pad_event) begin
          state_nxt = S_IDLE;
        end else if (sts.out_free) begin
          cmd.out_load = 1'b1;
          cmd.out_src  = SRC_PAD;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule

@@ rtl/csie_datapath.sv @@
// Datapath: stored surface state, bitmap scan registers and output register.
module csie_datapath #(
  parameter int BUTTON_BITS = csie_pkg::BUTTON_BITS_DEF,
  parameter int PAD_COUNT   = csie_pkg::PAD_COUNT_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic [csie_pkg::IN_TDATA_W-1:0]   in_tdata,
  input  csie_pkg::cmd_t                    cmd,
  output csie_pkg::status_t                 sts,
  input  logic                              thr_we,
  input  logic [csie_pkg::PRESS_W-1:0]      thr_wdata,
  output logic [csie_pkg::PRESS_W-1:0]      thr_q,
  input  logic                              out_tready,
  output logic                              out_tvalid,
  output logic [csie_pkg::OUT_TDATA_W-1:0]  out_tdata,
  output logic [csie_pkg::EVT_KIND_W-1:0]   out_tuser,
  output logic                              out_tlast
);
  import csie_pkg::*;

  localparam int PW = $clog2(BUTTON_BITS);

  logic [BUTTON_BITS-1:0] btn_state_r, diff_r, new_sh_r;
  logic [BUTTON_BITS-1:0] bits_ext, emit_mask, diff_full;
  logic [PW-1:0]          pos_r;
  logic [7:0]             last_enc_r, enc_in;
  logic                   enc_pend_r, up_r, up_in;
  logic [PAD_COUNT-1:0]   pad_active_r, pad_sel;
  logic [3:0]             pad_r, pad_in;
  logic [PRESS_W-1:0]     pres_r, pres_in, thr_r;
  logic                   over_r, in_range_r, pad_hit;
  logic                   out_valid_r;
  logic [OUT_TDATA_W-1:0] out_data_r, out_data_nxt;
  logic [EVT_KIND_W-1:0]  out_kind_r, out_kind_nxt;
  logic                   out_last_r, out_last_nxt;

  // Unpack the input item
  assign bits_ext = BUTTON_BITS'(in_tdata[31:0]);
  assign enc_in   = in_tdata[39:32];
  assign pad_in   = in_tdata[55:52];
  assign pres_in  = {in_tdata[51:48], in_tdata[47:40]};

  // Positions that report a change: not shift, not the silent group
  always_comb begin
    for (int i = 0; i < BUTTON_BITS; i++) begin
      emit_mask[i] = !((i == 0) || ((i >= 8) && (i <= 10)));
    end
  end
  assign diff_full = (bits_ext ^ btn_state_r) & emit_mask;

  // Encoder direction, with the 15 to 0 wrap counted as up
  assign up_in = ((last_enc_r < enc_in) || ((last_enc_r == 8'h0F) && (enc_in == 8'h00)))
                 && !((last_enc_r == 8'h00) && (enc_in == 8'h0F));

  // Threshold register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r <= THRESHOLD_RESET;
    end else if (thr_we) begin
      thr_r <= thr_wdata;
    end
  end
  assign thr_q = thr_r;

  // Stored button and encoder state, updated when a button report is taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      btn_state_r <= '0;
      last_enc_r  <= '0;
      enc_pend_r  <= 1'b0;
      diff_r      <= '0;
    end else if (cmd.load_btn) begin
      btn_state_r <= bits_ext;
      last_enc_r  <= enc_in;
      enc_pend_r  <= (enc_in != last_enc_r);
      diff_r      <= diff_full >> 1;
    end else if (cmd.scan_adv) begin
      diff_r <= diff_r >> 1;
    end
  end

  // Scan position and the new bits shifted along with the change mask
  always_ff @(posedge clk) begin
    if (cmd.load_btn) begin
      new_sh_r <= bits_ext >> 1;
      pos_r    <= PW'(1);
      up_r     <= up_in;
    end else if (cmd.scan_adv) begin
      new_sh_r <= new_sh_r >> 1;
      pos_r    <= pos_r + 1'b1;
    end
  end

  // Capture a pad entry
  always_ff @(posedge clk) begin
    if (cmd.load_pad) begin
      pad_r      <= pad_in;
      pres_r     <= pres_in;
      over_r     <= (pres_in > thr_r);
      in_range_r <= (5'(pad_in) < 5'(PAD_COUNT));
    end
  end

  assign pad_sel = PAD_COUNT'(1) << pad_r;
  assign pad_hit = |(pad_active_r & pad_sel);

  // Set or clear the pad's active flag when its event goes out
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pad_active_r <= '0;
    end else if (cmd.out_load && (cmd.out_src == SRC_PAD)) begin
      if (over_r) begin
        pad_active_r <= pad_active_r | pad_sel;
      end else begin
        pad_active_r <= pad_active_r & ~pad_sel;
      end
    end
  end

  // Build the next result item
  always_comb begin
    out_data_nxt = '0;
    out_data_nxt[6] = btn_state_r[0];
    case (cmd.out_src)
      SRC_BTN: begin
        out_kind_nxt      = EV_BUTTON;
        out_data_nxt[4:0] = 5'(pos_r);
        out_data_nxt[5]   = new_sh_r[0];
        out_last_nxt      = ~|diff_r[BUTTON_BITS-1:1] && !enc_pend_r;
      end
      SRC_ENC: begin
        out_kind_nxt    = EV_ENCODER;
        out_data_nxt[7] = up_r;
        out_last_nxt    = 1'b1;
      end
      SRC_PAD: begin
        out_kind_nxt       = over_r ? EV_PRESS : EV_RELEASE;
        out_data_nxt[11:8] = pad_r;
        out_data_nxt[23:12] = over_r ? pres_r : '0;
        out_last_nxt       = 1'b1;
      end
      default: begin
        out_kind_nxt = EV_BUTTON;
        out_last_nxt = 1'b1;
      end
    endcase
  end

  // Output register: hold until taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_data_r <= out_data_nxt;
      out_kind_r <= out_kind_nxt;
      out_last_r <= out_last_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_kind_r;
  assign out_tlast  = out_last_r;

  // Status toward the controller
  assign sts.cur_bit    = diff_r[0];
  assign sts.diff_empty = ~|diff_r;
  assign sts.enc_pend   = enc_pend_r;
  assign sts.pad_event  = in_range_r && (over_r || pad_hit);
  assign sts.out_free   = !out_valid_r || out_tready;

endmodule

@@ rtl/control_surface_input_events.sv @@
// Top level of the control-surface event block.
//
//  channel | dir | handshake          | payload
//  in_     | in  | tvalid/tready      | tdata button/encoder/pad bytes, tuser report kind
//  out_    | out | tvalid/tready/last | tdata event fields, tuser event kind
//  cfg_    | in  | APB psel/penable   | pad_threshold at byte address 0
//
// A report is taken in the idle state. A button report then walks the change mask one
// position per cycle, stalling while the output register is full, up to the highest
// changed one, sees the mask empty and sends the encoder event if the encoder moved;
// a pad entry is handled in the pad state. The bit-serial scan sets the worst case.
// A full output register stalls any event until taken. Reset is synchronous: all
// buttons released, encoder zero, pads inactive, threshold 200.
module control_surface_input_events #(
  parameter int BUTTON_BITS = csie_pkg::BUTTON_BITS_DEF,
  parameter int PAD_COUNT   = csie_pkg::PAD_COUNT_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  // button_bits[31:0], encoder_position[39:32], pad_low_byte[47:40], pad_high_byte[55:48]
  input  logic [csie_pkg::IN_TDATA_W-1:0]   in_tdata,
  // operation[0]
  input  logic                              in_tuser,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  // button_position[4:0], pressed[5], shift_held[6], step_up[7], pad_number[11:8],
  // pressure[23:12]
  output logic [csie_pkg::OUT_TDATA_W-1:0]  out_tdata,
  // event_kind[1:0]
  output logic [csie_pkg::EVT_KIND_W-1:0]   out_tuser,
  output logic                              out_tlast,
  input  logic                              cfg_psel,
  input  logic                              cfg_penable,
  input  logic                              cfg_pwrite,
  input  logic [2:0]                        cfg_paddr,
  input  logic [31:0]                       cfg_pwdata,
  output logic [31:0]                       cfg_prdata,
  output logic                              cfg_pready
);
  import csie_pkg::*;

  cmd_t               cmd;
  status_t            sts;
  logic               thr_we;
  logic [PRESS_W-1:0] thr_q;

  // Decode the configuration port
  assign cfg_pready = 1'b1;
  assign thr_we     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready
                      && (cfg_paddr[2] == REG_PAD_THRESHOLD);
  assign cfg_prdata = (cfg_paddr[2] == REG_PAD_THRESHOLD) ? {20'b0, thr_q} : 32'b0;

  csie_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_op     (in_tuser),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  csie_datapath #(
    .BUTTON_BITS (BUTTON_BITS),
    .PAD_COUNT   (PAD_COUNT)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .cmd        (cmd),
    .sts        (sts),
    .thr_we     (thr_we),
    .thr_wdata  (cfg_pwdata[PRESS_W-1:0]),
    .thr_q      (thr_q),
    .out_tready (out_tready),
    .out_tvalid (out_tvalid),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

endmodule

@@ rtl/csie_checker.sv @@
// Port-level checker of the event block and its bind.
`include "control_surface_input_events_macros.svh"

module csie_checker (
  input logic                              clk,
  input logic                              rst_n,
  input logic                              out_tvalid,
  input logic                              out_tready,
  input logic [csie_pkg::OUT_TDATA_W-1:0]  out_tdata,
  input logic [csie_pkg::EVT_KIND_W-1:0]   out_tuser,
  input logic                              out_tlast
);
  import csie_pkg::*;

  logic stalled;
  logic closing_kind;
  logic btn_pos_ok;

  // Conditions watched by the checks
  assign stalled      = out_tvalid && !out_tready;
  assign closing_kind = (out_tuser == EV_ENCODER) || (out_tuser == EV_PRESS)
                        || (out_tuser == EV_RELEASE);
  assign btn_pos_ok   = (out_tdata[4:0] != 5'd0)
                        && ((out_tdata[4:0] < 5'd8) || (out_tdata[4:0] > 5'd10));

  // a stalled item stays offered
  `CSIE_ASSERT_NEXT(a_out_hold, clk, rst_n, stalled, out_tvalid)
  // a stalled item keeps its payload
  `CSIE_ASSERT_NEXT(a_out_stable, clk, rst_n, stalled, $stable({out_tdata, out_tuser, out_tlast}))
  // encoder and pad events always close their report
  `CSIE_ASSERT_SAME(a_single_last, clk, rst_n, out_tvalid && closing_kind, out_tlast)
  // a release carries no pressure
  `CSIE_ASSERT_SAME(a_release_zero, clk, rst_n, out_tvalid && (out_tuser == EV_RELEASE), out_tdata[23:12] == 12'd0)
  // button events never name shift or the silent group
  `CSIE_ASSERT_SAME(a_btn_pos, clk, rst_n, out_tvalid && (out_tuser == EV_BUTTON), btn_pos_ok)

endmodule

bind control_surface_input_events csie_checker u_csie_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser),
  .out_tlast  (out_tlast)
);

@@ bench/control_surface_input_events_checker.sv @@
// Event checker: predicts the events of each accepted report and compares the result stream.
module control_surface_input_events_checker (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  input  logic                             in_tready,
  input  logic [csie_pkg::IN_TDATA_W-1:0]  in_tdata,
  input  logic                             in_tuser,
  input  logic                             out_tvalid,
  input  logic                             out_tready,
  input  logic [csie_pkg::OUT_TDATA_W-1:0] out_tdata,
  input  logic [csie_pkg::EVT_KIND_W-1:0]  out_tuser,
  input  logic                             out_tlast,
  input  logic                             cfg_psel,
  input  logic                             cfg_penable,
  input  logic                             cfg_pwrite,
  input  logic [2:0]                       cfg_paddr,
  input  logic [31:0]                      cfg_pwdata,
  input  logic                             cfg_pready,
  output int                               fail_count,
  output int                               events_checked,
  output int                               events_pending
);
  timeunit 1ns;
  timeprecision 1ps;
  import csie_pkg::*;

  localparam logic [2:0] THRESHOLD_ADDR = {REG_PAD_THRESHOLD, 2'b00};

  typedef struct packed {
    event_kind_t  kind;
    logic [4:0]   button_pos;
    logic         pressed;
    logic         shift;
    logic         step_up;
    logic [3:0]   pad;
    logic [11:0]  pressure;
    logic         is_last;
  } surface_event_t;

  // Shadow of the block's state and its threshold register
  logic [BUTTON_BITS_DEF-1:0] held_buttons;
  logic [7:0]                 encoder_seen;
  logic [PAD_COUNT_DEF-1:0]   pad_down;
  logic [PRESS_W-1:0]         press_threshold;

  surface_event_t event_q[$];
  bit             result_bad;

  // Work out the events one report causes and queue them in order
  task automatic predict_events(input logic op, input logic [IN_TDATA_W-1:0] data);
    surface_event_t evs[$];
    surface_event_t ev;
    logic [31:0]    bits;
    logic [7:0]     enc;
    logic           shift;
    logic [3:0]     pad;
    logic [11:0]    pres;
    int             p;
    if (op == OP_BUTTON) begin
      bits  = data[31:0];
      enc   = data[39:32];
      shift = bits[0];
      // shift is stored but never reported as a button event
      held_buttons[0] = shift;
      for (p = 1; p < BUTTON_BITS_DEF; p++) begin
        if (bits[p] != held_buttons[p]) begin
          held_buttons[p] = bits[p];
          // positions 8 to 10 are tracked silently
          if (p < 8 || p > 10) begin
            ev = '0;
            ev.kind       = EV_BUTTON;
            ev.button_pos = 5'(p);
            ev.pressed    = bits[p];
            ev.shift      = shift;
            evs.push_back(ev);
          end
        end
      end
      if (enc != encoder_seen) begin
        ev = '0;
        ev.kind  = EV_ENCODER;
        ev.shift = shift;
        // 15 -> 0 wraps upward, 0 -> 15 wraps downward
        ev.step_up = ((encoder_seen < enc) || (encoder_seen == 8'h0F && enc == 8'h00))
                     && !(encoder_seen == 8'h00 && enc == 8'h0F);
        evs.push_back(ev);
        encoder_seen = enc;
      end
    end else begin
      pad   = data[55:52];
      pres  = {data[51:48], data[47:40]};
      shift = held_buttons[0];
      if (int'(pad) < PAD_COUNT_DEF) begin
        if (pres > press_threshold) begin
          pad_down[pad] = 1'b1;
          ev = '0;
          ev.kind     = EV_PRESS;
          ev.shift    = shift;
          ev.pad      = pad;
          ev.pressure = pres;
          evs.push_back(ev);
        end else if (pad_down[pad]) begin
          pad_down[pad] = 1'b0;
          ev = '0;
          ev.kind  = EV_RELEASE;
          ev.shift = shift;
          ev.pad   = pad;
          evs.push_back(ev);
        end
      end
    end
    if (evs.size() > 0) evs[evs.size()-1].is_last = 1'b1;
    foreach (evs[i]) event_q.push_back(evs[i]);
  endtask

  task automatic check_field(input string name, input int unsigned want, input int unsigned got);
    if (want != got) begin
      $display("%0t ns: %s expected %0d actual %0d", $time, name, want, got);
      result_bad = 1'b1;
    end
  endtask

  always @(posedge clk) begin
    surface_event_t want;
    if (!rst_n) begin
      held_buttons    = '0;
      encoder_seen    = '0;
      pad_down        = '0;
      press_threshold = THRESHOLD_RESET;
      event_q.delete();
      fail_count     <= 0;
      events_checked <= 0;
    end else begin
      // track threshold writes
      if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready && cfg_paddr == THRESHOLD_ADDR)
        press_threshold = cfg_pwdata[PRESS_W-1:0];
      if (in_tvalid && in_tready)
        predict_events(in_tuser, in_tdata);
      // compare each result item with the oldest expectation
      if (out_tvalid && out_tready) begin
        events_checked <= events_checked + 1;
        if (event_q.size() == 0) begin
          $display("%0t ns: unexpected event, kind %0d tdata 0x%06h last %0b",
                   $time, out_tuser, out_tdata, out_tlast);
          fail_count <= fail_count + 1;
        end else begin
          want = event_q.pop_front();
          result_bad = 1'b0;
          check_field("event_kind", want.kind, out_tuser);
          check_field("button_position", want.button_pos, out_tdata[4:0]);
          check_field("pressed", want.pressed, out_tdata[5]);
          check_field("shift_held", want.shift, out_tdata[6]);
          check_field("step_up", want.step_up, out_tdata[7]);
          check_field("pad_number", want.pad, out_tdata[11:8]);
          check_field("pressure", want.pressure, out_tdata[23:12]);
          check_field("last", want.is_last, out_tlast);
          if (result_bad) fail_count <= fail_count + 1;
        end
      end
    end
    events_pending <= event_q.size();
  end

endmodule

@@ bench/control_surface_input_events_tb.sv @@
// Top of the event block bench: clock, reset, report stimulus, threshold phases and verdict.
module control_surface_input_events_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import csie_pkg::*;

  localparam int         CLK_PERIOD     = 20;
  localparam int         CYCLE_LIMIT    = 4000000;
  localparam int         SETTLE_CYCLES  = 64;
  localparam int         ITEMS_PER_SET  = 84;
  localparam logic [2:0] THRESHOLD_ADDR = {REG_PAD_THRESHOLD, 2'b00};

  logic                   clk         = 1'b0;
  logic                   rst_n       = 1'b0;
  logic                   in_tvalid   = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata    = '0;
  logic                   in_tuser    = OP_BUTTON;
  logic                   out_tvalid;
  logic                   out_tready  = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic [EVT_KIND_W-1:0]  out_tuser;
  logic                   out_tlast;
  logic                   cfg_psel    = 1'b0;
  logic                   cfg_penable = 1'b0;
  logic                   cfg_pwrite  = 1'b0;
  logic [2:0]             cfg_paddr   = '0;
  logic [31:0]            cfg_pwdata  = '0;
  logic [31:0]            cfg_prdata;
  logic                   cfg_pready;

  int fail_count;
  int events_checked;
  int events_pending;

  // stimulus bookkeeping
  bit          idle_on  = 1'b1;
  int          stall_left = 0;
  int          cycle_count = 0;
  int          reports_sent = 0;
  int          settings_used = 1;
  logic [31:0] sent_bits = '0;
  logic [7:0]  sent_enc = '0;
  int unsigned cur_threshold = 32'(THRESHOLD_RESET);

  always #(CLK_PERIOD/2) clk = ~clk;

  control_surface_input_events i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast),
    .cfg_psel   (cfg_psel),
    .cfg_penable(cfg_penable),
    .cfg_pwrite (cfg_pwrite),
    .cfg_paddr  (cfg_paddr),
    .cfg_pwdata (cfg_pwdata),
    .cfg_prdata (cfg_prdata),
    .cfg_pready (cfg_pready)
  );

  control_surface_input_events_checker i_event_check (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_tvalid     (in_tvalid),
    .in_tready     (in_tready),
    .in_tdata      (in_tdata),
    .in_tuser      (in_tuser),
    .out_tvalid    (out_tvalid),
    .out_tready    (out_tready),
    .out_tdata     (out_tdata),
    .out_tuser     (out_tuser),
    .out_tlast     (out_tlast),
    .cfg_psel      (cfg_psel),
    .cfg_penable   (cfg_penable),
    .cfg_pwrite    (cfg_pwrite),
    .cfg_paddr     (cfg_paddr),
    .cfg_pwdata    (cfg_pwdata),
    .cfg_pready    (cfg_pready),
    .fail_count    (fail_count),
    .events_checked(events_checked),
    .events_pending(events_pending)
  );

  // Stall the result side: mostly short stalls, a few long ones
  always @(posedge clk) begin
    int r;
    r = $urandom_range(0, 99);
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_tready <= 1'b0;
    end else if (idle_on && r < 15) begin
      stall_left <= $urandom_range(0, 2);
      out_tready <= 1'b0;
    end else if (idle_on && r < 17) begin
      stall_left <= $urandom_range(20, 60);
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
    end
  end

  // Bound the run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("run timed out after %0d cycles, %0d events still due", cycle_count,
               events_pending);
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // Offer one report, hold it until taken, then at times idle for a random while
  task automatic send_report(input logic op, input logic [31:0] bits, input logic [7:0] enc,
                             input logic [7:0] lo, input logic [7:0] hi);
    int r;
    int gap;
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= {hi, lo, enc, bits};
    do @(posedge clk); while (!in_tready);
    reports_sent++;
    r = $urandom_range(0, 99);
    gap = 0;
    if (idle_on) begin
      if (r < 30)      gap = $urandom_range(1, 3);
      else if (r < 36) gap = $urandom_range(4, 12);
      else if (r < 38) gap = $urandom_range(30, 80);
    end
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic send_buttons(input logic [31:0] bits, input logic [7:0] enc);
    send_report(OP_BUTTON, bits, enc, 8'($urandom), 8'($urandom));
    sent_bits = bits;
    sent_enc  = enc;
  endtask

  task automatic send_pad(input logic [3:0] pad, input logic [11:0] pres);
    logic [31:0] junk_bits;
    junk_bits = $urandom;
    send_report(OP_PAD, junk_bits, 8'($urandom), pres[7:0], {pad, pres[11:8]});
  endtask

  // Let every due event drain, then give the scan time to finish
  task automatic settle();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (events_pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_threshold(input int unsigned value);
    cfg_psel    <= 1'b1;
    cfg_pwrite  <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_paddr   <= THRESHOLD_ADDR;
    cfg_pwdata  <= value;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    @(posedge clk);
    cur_threshold = value;
    settings_used++;
  endtask

  // One random report: mostly small button changes and pad runs on a few pads
  task automatic random_report();
    logic [31:0] bits;
    logic [7:0]  enc;
    logic [3:0]  pad;
    logic [11:0] pres;
    int          r;
    int          k;
    if ($urandom_range(0, 99) < 45) begin
      bits = sent_bits;
      r = $urandom_range(0, 99);
      if (r < 60) begin
        for (k = 0; k < $urandom_range(1, 3); k++) bits[$urandom_range(0, 31)] ^= 1'b1;
      end else if (r < 90) begin
        if (r >= 75) bits = $urandom;
      end else begin
        bits = ~sent_bits;
      end
      enc = sent_enc;
      r = $urandom_range(0, 99);
      if (r < 35)      enc = sent_enc + 8'd1;
      else if (r < 60) enc = sent_enc - 8'd1;
      else if (r < 68) enc = (sent_enc == 8'h0F) ? 8'h00 : 8'h0F;
      else if (r >= 80) enc = 8'($urandom);
      send_buttons(bits, enc);
    end else begin
      pad = ($urandom_range(0, 99) < 70) ? 4'($urandom_range(0, 3)) : 4'($urandom);
      r = $urandom_range(0, 99);
      if (r < 45 && cur_threshold < 4095)
        pres = 12'($urandom_range(cur_threshold + 1, 4095));
      else if (r < 85)
        pres = 12'($urandom_range(0, cur_threshold));
      else
        pres = 12'($urandom);
      send_pad(pad, pres);
    end
  endtask

  initial begin
    int unsigned settings[5];
    int s;
    int n;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: bitmap extremes, shift, silent positions, encoder wraps, pad edges
    send_buttons(32'h0000_0000, 8'h00);
    send_buttons(32'hFFFF_FFFF, 8'h01);
    send_buttons(32'h0000_0000, 8'h0F);
    send_buttons(32'h0000_0000, 8'h00);
    send_buttons(32'h0000_0000, 8'h0F);
    send_buttons(32'h0000_0700, 8'h0F);
    send_buttons(32'h0000_0001, 8'h0E);
    send_buttons(32'h8000_0003, 8'hFF);
    send_buttons(32'h8000_0003, 8'hFF);
    send_buttons(32'h0000_0001, 8'h00);
    send_pad(4'd0, 12'd200);
    send_pad(4'd0, 12'd201);
    send_pad(4'd0, 12'd4095);
    send_pad(4'd0, 12'd200);
    send_pad(4'd0, 12'd0);
    send_pad(4'd15, 12'd4095);
    send_pad(4'd15, 12'd0);
    send_pad(4'd15, 12'd0);
    send_buttons(32'h0000_0000, 8'h80);
    send_pad(4'd7, 12'd3000);
    send_pad(4'd7, 12'd150);
    send_buttons(32'h5555_5555, 8'h7F);
    send_buttons(32'hAAAA_AAAA, 8'h80);
    settle();

    // Random phases over several thresholds, extremes included
    settings[0] = 0;
    settings[1] = 4095;
    settings[2] = $urandom_range(1, 4094);
    settings[3] = 32'(THRESHOLD_RESET);
    settings[4] = 1;
    for (s = 0; s < 5; s++) begin
      write_threshold(settings[s]);
      // one phase runs without any idling
      idle_on = (s != 3);
      for (n = 0; n < ITEMS_PER_SET; n++) random_report();
      settle();
    end

    $display("sent %0d reports under %0d threshold settings, compared %0d events",
             reports_sent, settings_used, events_checked);
    if (fail_count == 0 && events_pending == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
